// ===== rtl/gpc_pkg.sv =====
package gpc_pkg;

    localparam int MAX_N       = 65536;
    localparam int FIELD_W     = 17;
    localparam int CNT_W       = 33;
    localparam int N_W         = $clog2(MAX_N + 1);
    localparam int I_W         = N_W + 1;
    localparam int PRIME_DEPTH = MAX_N / 2 + 2;
    localparam int PIDX_W      = $clog2(PRIME_DEPTH);
    localparam int MERT_W      = 16;
    localparam int PROD1_W     = MERT_W + 1 + N_W + 1;
    localparam int PROD2_W     = PROD1_W + N_W + 1;
    localparam int SUM_W       = PROD2_W + 8;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    typedef logic signed [1:0] mu_t;

    typedef struct packed {
        logic              comp;
        mu_t               mu;
        logic [PIDX_W-1:0] lpf;
    } sieve_entry_t;

    typedef struct packed {
        logic           start;
        logic [N_W-1:0] dividend;
        logic [N_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic           done;
        logic [N_W-1:0] quotient;
    } div_rsp_t;

    typedef struct packed {
        logic cleared;
        logic ready;
    } sieve_status_t;

endpackage

// ===== rtl/gpc_divider.sv =====
module gpc_divider
    import gpc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int CW = $clog2(N_W + 1);

    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [N_W-1:0] quo_reg, quo_next;
    logic [N_W-1:0] rem_reg, rem_next;
    logic [N_W-1:0] dsr_reg, dsr_next;
    logic [N_W:0]   shifted;
    logic [N_W:0]   trial;

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        shifted   = {rem_reg, quo_reg[N_W-1]};
        trial     = shifted - {1'b0, dsr_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(N_W);
            quo_next  = req.dividend;
            rem_next  = '0;
            dsr_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[N_W])
            begin
                rem_next = trial[N_W-1:0];
                quo_next = {quo_reg[N_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[N_W-1:0];
                quo_next = {quo_reg[N_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== rtl/gpc_sieve.sv =====
module gpc_sieve
    import gpc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     build,
    output sieve_status_t            status,
    input  logic [N_W-1:0]           mert_addr,
    output logic signed [MERT_W-1:0] mert_data
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RD_I,
        S_GOT_I,
        S_RD_P,
        S_GOT_P
    } state_t;

    state_t                    state_reg, state_next;
    logic [N_W-1:0]            addr_reg, addr_next;
    logic [PIDX_W-1:0]         j_reg, j_next;
    logic [PIDX_W-1:0]         ptot_reg, ptot_next;
    logic [PIDX_W-1:0]         lpf_reg, lpf_next;
    mu_t                       mu_reg, mu_next;
    logic signed [MERT_W-1:0]  mrun_reg, mrun_next;
    logic                      ready_reg, ready_next;

    sieve_entry_t              sv_mem [0:MAX_N];
    logic [N_W-1:0]            pr_mem [0:PRIME_DEPTH-1];
    logic signed [MERT_W-1:0]  mt_mem [0:MAX_N];

    sieve_entry_t              sv_rd_reg;
    logic [N_W-1:0]            pr_rd_reg;
    logic signed [MERT_W-1:0]  mt_rd_reg;

    logic                      sv_we, pr_we, mt_we;
    logic [N_W-1:0]            sv_waddr, mt_waddr;
    sieve_entry_t              sv_wdata;
    logic signed [MERT_W-1:0]  mt_wdata;
    logic [2*N_W-1:0]          prod;
    mu_t                       mu_cur;
    logic [PIDX_W-1:0]         lpf_cur;
    logic                      last_i;

    always_comb
    begin
        state_next = state_reg;
        addr_next  = addr_reg;
        j_next     = j_reg;
        ptot_next  = ptot_reg;
        lpf_next   = lpf_reg;
        mu_next    = mu_reg;
        mrun_next  = mrun_reg;
        ready_next = ready_reg;
        sv_we      = 1'b0;
        sv_waddr   = addr_reg;
        sv_wdata   = '0;
        pr_we      = 1'b0;
        mt_we      = 1'b0;
        mt_waddr   = addr_reg;
        mt_wdata   = '0;
        prod       = addr_reg * pr_rd_reg;
        mu_cur     = sv_rd_reg.mu;
        lpf_cur    = sv_rd_reg.lpf;
        last_i     = (addr_reg == N_W'(MAX_N));
        case (state_reg)
            S_CLEAR:
            begin
                sv_we    = 1'b1;
                mt_we    = 1'b1;
                mt_wdata = (addr_reg == N_W'(1)) ? MERT_W'(1) : '0;
                if (last_i)
                begin
                    addr_next  = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    addr_next = addr_reg + N_W'(1);
                end
            end
            S_IDLE:
            begin
                if (build && !ready_reg)
                begin
                    addr_next  = N_W'(2);
                    mrun_next  = MERT_W'(1);
                    ptot_next  = '0;
                    state_next = S_RD_I;
                end
            end
            S_RD_I:
            begin
                state_next = S_GOT_I;
            end
            S_GOT_I:
            begin
                if (!sv_rd_reg.comp)
                begin
                    // new prime: mu = -1, it is its own least factor
                    mu_cur    = 2'sb11;
                    lpf_cur   = ptot_reg;
                    pr_we     = 1'b1;
                    ptot_next = ptot_reg + PIDX_W'(1);
                end
                mu_next    = mu_cur;
                lpf_next   = lpf_cur;
                mt_we      = 1'b1;
                mt_wdata   = mrun_reg + {{(MERT_W-2){mu_cur[1]}}, mu_cur};
                mrun_next  = mt_wdata;
                j_next     = '0;
                state_next = S_RD_P;
            end
            S_RD_P:
            begin
                state_next = S_GOT_P;
            end
            S_GOT_P:
            begin
                if (prod > (2*N_W)'(MAX_N) || j_reg == lpf_reg)
                begin
                    if (prod <= (2*N_W)'(MAX_N))
                    begin
                        // p divides i: square factor
                        sv_we    = 1'b1;
                        sv_waddr = prod[N_W-1:0];
                        sv_wdata = '{comp: 1'b1, mu: 2'sb00, lpf: j_reg};
                    end
                    if (last_i)
                    begin
                        ready_next = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        addr_next  = addr_reg + N_W'(1);
                        state_next = S_RD_I;
                    end
                end
                else
                begin
                    sv_we      = 1'b1;
                    sv_waddr   = prod[N_W-1:0];
                    sv_wdata   = '{comp: 1'b1, mu: -mu_reg, lpf: j_reg};
                    j_next     = j_reg + PIDX_W'(1);
                    state_next = S_RD_P;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            addr_reg  <= '0;
            j_reg     <= '0;
            ptot_reg  <= '0;
            lpf_reg   <= '0;
            mu_reg    <= '0;
            mrun_reg  <= '0;
            ready_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            j_reg     <= j_next;
            ptot_reg  <= ptot_next;
            lpf_reg   <= lpf_next;
            mu_reg    <= mu_next;
            mrun_reg  <= mrun_next;
            ready_reg <= ready_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sv_we)
        begin
            sv_mem[sv_waddr] <= sv_wdata;
        end
        sv_rd_reg <= sv_mem[addr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (pr_we)
        begin
            pr_mem[ptot_reg] <= addr_reg;
        end
        pr_rd_reg <= pr_mem[j_reg];
    end

    always_ff @(posedge clk)
    begin
        if (mt_we)
        begin
            mt_mem[mt_waddr] <= mt_wdata;
        end
        mt_rd_reg <= mt_mem[mert_addr];
    end

    assign mert_data      = mt_rd_reg;
    assign status.cleared = (state_reg != S_CLEAR);
    assign status.ready   = ready_reg;

endmodule

// ===== rtl/gpc_query.sv =====
module gpc_query
    import gpc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [FIELD_W-1:0]       limit_a,
    input  logic [FIELD_W-1:0]       limit_b,
    input  logic [FIELD_W-1:0]       divisor,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [CNT_W-1:0]         pair_count,
    output logic                     build,
    input  sieve_status_t            sv_status,
    output logic [N_W-1:0]           mert_addr,
    input  logic signed [MERT_W-1:0] mert_data,
    output div_req_t                 div_req,
    input  div_rsp_t                 div_rsp
);

    typedef enum logic [3:0] {
        Q_IDLE,
        Q_BUILD,
        Q_DIV_GO,
        Q_DIV_WAIT,
        Q_LOOP,
        Q_RM1,
        Q_RM2,
        Q_RM3,
        Q_MUL,
        Q_DONE
    } state_t;

    typedef enum logic [2:0] {
        D_N1,
        D_M1,
        D_QN,
        D_QM,
        D_HN,
        D_HM
    } dsel_t;

    state_t                    state_reg, state_next;
    dsel_t                     sel_reg, sel_next;
    logic [N_W-1:0]            n_reg, n_next, m_reg, m_next, d_reg, d_next;
    logic [N_W-1:0]            n1_reg, n1_next, m1_reg, m1_next;
    logic [N_W-1:0]            qn_reg, qn_next, qm_reg, qm_next;
    logic [N_W-1:0]            hn_reg, hn_next, hi_reg, hi_next;
    logic [I_W-1:0]            i_reg, i_next;
    logic signed [MERT_W-1:0]  mhi_reg, mhi_next;
    logic signed [PROD1_W-1:0] prod1_reg, prod1_next;
    logic signed [SUM_W-1:0]   sum_reg, sum_next;
    logic                      zero_reg, zero_next;
    logic                      out_valid_reg, out_valid_next;
    logic [CNT_W-1:0]          count_reg, count_next;

    logic [N_W-1:0]            a_cl, b_cl, lo_cl, hi_cl;
    logic signed [MERT_W:0]    diff;
    logic signed [N_W:0]       qn_s, qm_s;
    logic signed [PROD2_W-1:0] prod2;
    logic [CNT_W-1:0]          result;

    always_comb
    begin
        a_cl  = ({15'd0, limit_a} > 32'(MAX_N)) ? N_W'(MAX_N) : N_W'(limit_a);
        b_cl  = ({15'd0, limit_b} > 32'(MAX_N)) ? N_W'(MAX_N) : N_W'(limit_b);
        lo_cl = (a_cl < b_cl) ? a_cl : b_cl;
        hi_cl = (a_cl < b_cl) ? b_cl : a_cl;
        diff  = {mhi_reg[MERT_W-1], mhi_reg} - {mert_data[MERT_W-1], mert_data};
        qn_s  = {1'b0, qn_reg};
        qm_s  = {1'b0, qm_reg};
        prod2 = prod1_reg * qm_s;
        if (zero_reg || sum_reg[SUM_W-1])
            result = '0;
        else if (sum_reg[SUM_W-2:0] > (SUM_W-1)'(COUNT_MAX))
            result = COUNT_MAX;
        else
            result = sum_reg[CNT_W-1:0];
    end

    always_comb
    begin
        state_next     = state_reg;
        sel_next       = sel_reg;
        n_next         = n_reg;
        m_next         = m_reg;
        d_next         = d_reg;
        n1_next        = n1_reg;
        m1_next        = m1_reg;
        qn_next        = qn_reg;
        qm_next        = qm_reg;
        hn_next        = hn_reg;
        hi_next        = hi_reg;
        i_next         = i_reg;
        mhi_next       = mhi_reg;
        prod1_next     = prod1_reg;
        sum_next       = sum_reg;
        zero_next      = zero_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && out_stall;
        div_req        = '0;
        case (sel_reg)
            D_N1:
            begin
                div_req.dividend = n_reg;
                div_req.divisor  = d_reg;
            end
            D_M1:
            begin
                div_req.dividend = m_reg;
                div_req.divisor  = d_reg;
            end
            D_QN:
            begin
                div_req.dividend = n1_reg;
                div_req.divisor  = i_reg[N_W-1:0];
            end
            D_QM:
            begin
                div_req.dividend = m1_reg;
                div_req.divisor  = i_reg[N_W-1:0];
            end
            D_HN:
            begin
                div_req.dividend = n1_reg;
                div_req.divisor  = qn_reg;
            end
            D_HM:
            begin
                div_req.dividend = m1_reg;
                div_req.divisor  = qm_reg;
            end
            default:
            begin
                div_req.dividend = n_reg;
                div_req.divisor  = d_reg;
            end
        endcase
        case (state_reg)
            Q_IDLE:
            begin
                if (in_valid && sv_status.cleared)
                begin
                    n_next     = lo_cl;
                    m_next     = hi_cl;
                    d_next     = N_W'(divisor);
                    // zero divisor, or divisor beyond the smaller limit
                    zero_next  = (divisor == '0) || ({15'd0, divisor} > 32'(lo_cl));
                    sum_next   = '0;
                    state_next = Q_BUILD;
                end
            end
            Q_BUILD:
            begin
                if (sv_status.ready)
                begin
                    sel_next   = D_N1;
                    state_next = zero_reg ? Q_DONE : Q_DIV_GO;
                end
            end
            Q_DIV_GO:
            begin
                div_req.start = 1'b1;
                state_next    = Q_DIV_WAIT;
            end
            Q_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = Q_DIV_GO;
                    case (sel_reg)
                        D_N1:
                        begin
                            n1_next  = div_rsp.quotient;
                            sel_next = D_M1;
                        end
                        D_M1:
                        begin
                            m1_next    = div_rsp.quotient;
                            i_next     = I_W'(1);
                            state_next = Q_LOOP;
                        end
                        D_QN:
                        begin
                            qn_next  = div_rsp.quotient;
                            sel_next = D_QM;
                        end
                        D_QM:
                        begin
                            qm_next  = div_rsp.quotient;
                            sel_next = D_HN;
                        end
                        D_HN:
                        begin
                            hn_next  = div_rsp.quotient;
                            sel_next = D_HM;
                        end
                        D_HM:
                        begin
                            hi_next    = (hn_reg < div_rsp.quotient) ? hn_reg
                                                                     : div_rsp.quotient;
                            state_next = Q_RM1;
                        end
                        default:
                        begin
                            state_next = Q_DONE;
                        end
                    endcase
                end
            end
            Q_LOOP:
            begin
                if (i_reg > I_W'(n1_reg))
                begin
                    state_next = Q_DONE;
                end
                else
                begin
                    sel_next   = D_QN;
                    state_next = Q_DIV_GO;
                end
            end
            Q_RM1:
            begin
                state_next = Q_RM2;
            end
            Q_RM2:
            begin
                mhi_next   = mert_data;
                state_next = Q_RM3;
            end
            Q_RM3:
            begin
                prod1_next = diff * qn_s;
                state_next = Q_MUL;
            end
            Q_MUL:
            begin
                sum_next   = sum_reg + SUM_W'(prod2);
                i_next     = I_W'(hi_reg) + I_W'(1);
                state_next = Q_LOOP;
            end
            Q_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    count_next     = result;
                    state_next     = Q_IDLE;
                end
            end
            default:
            begin
                state_next = Q_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= Q_IDLE;
            sel_reg       <= D_N1;
            zero_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            zero_reg      <= zero_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        m_reg     <= m_next;
        d_reg     <= d_next;
        n1_reg    <= n1_next;
        m1_reg    <= m1_next;
        qn_reg    <= qn_next;
        qm_reg    <= qm_next;
        hn_reg    <= hn_next;
        hi_reg    <= hi_next;
        i_reg     <= i_next;
        mhi_reg   <= mhi_next;
        prod1_reg <= prod1_next;
        sum_reg   <= sum_next;
        count_reg <= count_next;
    end

    assign in_stall   = !(state_reg == Q_IDLE && sv_status.cleared);
    assign build      = (state_reg == Q_BUILD);
    assign mert_addr  = (state_reg == Q_RM1) ? hi_reg : N_W'(i_reg - I_W'(1));
    assign out_valid  = out_valid_reg;
    assign pair_count = count_reg;

endmodule

// ===== rtl/gcd_pair_counter.sv =====
// After reset a clearing pass over the whole map runs with in_stall high.
// The first request also builds the Mobius/Mertens table.
// A request then walks its quotient blocks, each taking four divides on the shared divider.
// One request in flight at a time; a finished count waits in the output register.
// rst_n is asynchronous, active low; the table is rebuilt after every reset.
module gcd_pair_counter
    import gpc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [FIELD_W-1:0] limit_a,
    input  logic [FIELD_W-1:0] limit_b,
    input  logic [FIELD_W-1:0] divisor,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [CNT_W-1:0]   pair_count
);

    // sieve <-> query
    sieve_status_t            sv_status;
    logic                     build;
    logic [N_W-1:0]           mert_addr;
    logic signed [MERT_W-1:0] mert_data;

    // query <-> shared divider
    div_req_t                 div_req;
    div_rsp_t                 div_rsp;

    // Linear sieve: clears its map after reset, builds mu and Mertens on demand,
    // and serves Mertens reads from a registered read port.
    gpc_sieve u_sieve (
        .clk       (clk),
        .rst_n     (rst_n),
        .build     (build),
        .status    (sv_status),
        .mert_addr (mert_addr),
        .mert_data (mert_data)
    );

    // One restoring divider, reused for every quotient of a request.
    gpc_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Sequencer: walks the quotient blocks and accumulates the signed sum.
    gpc_query u_query (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .limit_a    (limit_a),
        .limit_b    (limit_b),
        .divisor    (divisor),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .pair_count (pair_count),
        .build      (build),
        .sv_status  (sv_status),
        .mert_addr  (mert_addr),
        .mert_data  (mert_data),
        .div_req    (div_req),
        .div_rsp    (div_rsp)
    );

endmodule

// ===== rtl/gpc_checker.sv =====
module gpc_checker
    import gpc_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic [CNT_W-1:0]   pair_count
);

    logic [1:0] pend_reg, pend_next;
    logic       in_acc, out_acc;

    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid && !out_stall;

    always_comb
    begin
        pend_next = pend_reg + 2'(in_acc) - 2'(out_acc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= '0;
        else
            pend_reg <= pend_next;
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(pair_count))
        else $error("output changed while stalled");

    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> in_stall)
        else $error("request taken while previous one in work");

    a_no_orphan_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != 2'd0)
        else $error("result without request");

    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg != 2'd3)
        else $error("too many requests outstanding");

endmodule

bind gcd_pair_counter gpc_checker u_gpc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .pair_count (pair_count)
);
